FILE: rtl/core/sibf_pkg.sv
// Shared types and constants for the source address blocklist filter.
package sibf_pkg;

    localparam int RULE_ENTRIES_DEF = 64;
    localparam int KEY_BITS         = 128;

    localparam logic       OP_FRAME_BYTE = 1'b0;
    localparam logic       OP_RULE_WRITE = 1'b1;

    localparam logic [5:0]  MAX_POSITION  = 6'd63;
    localparam logic [5:0]  POS_KIND_HI   = 6'd12;
    localparam logic [5:0]  POS_KIND_LO   = 6'd13;
    localparam logic [5:0]  LAST_POS_IPV4 = 6'd33;
    localparam logic [5:0]  LAST_POS_IPV6 = 6'd53;
    localparam logic [15:0] KIND_IPV4     = 16'h0800;
    localparam logic [15:0] KIND_IPV6     = 16'h86DD;
    localparam logic [15:0] IPV4_MAPPED   = 16'hffff;

    typedef logic [KEY_BITS-1:0] key_t;

    typedef struct packed {
        logic        operation;
        logic [7:0]  frame_byte;
        logic        frame_last;
        logic [5:0]  rule_index;
        logic        rule_valid;
        logic [7:0]  rule_prefix_length;
        logic [63:0] rule_address_high;
        logic [63:0] rule_address_low;
    } in_item_t;

    typedef struct packed {
        logic        verdict;
        logic        was_counted;
        logic [63:0] passed_total;
        logic [63:0] dropped_total;
    } out_item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] prefix_length;
        key_t       address;
    } rule_t;

    typedef struct packed {
        logic token;
        logic hit;
    } chain_t;

    typedef struct packed {
        logic counted;
        key_t key;
    } parse_t;

endpackage

FILE: rtl/core/sibf_parser.sv
// Frame header parser: tracks byte position, ethertype and source address.
module sibf_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_en,
    input  logic [7:0]       frame_byte,
    input  logic             frame_last,
    output sibf_pkg::parse_t parse
);
    import sibf_pkg::*;

    logic [5:0]  pos_reg, pos_next;
    logic [15:0] kind_reg, kind_next;
    logic [63:0] src_high_reg, src_high_next;
    logic [63:0] src_low_reg, src_low_next;

    always_comb
    begin
        pos_next      = pos_reg;
        kind_next     = kind_reg;
        src_high_next = src_high_reg;
        src_low_next  = src_low_reg;
        if (byte_en)
        begin
            if (frame_last)
            begin
                pos_next      = '0;
                kind_next     = '0;
                src_high_next = '0;
                src_low_next  = '0;
            end
            else
            begin
                case (pos_reg) inside
                    POS_KIND_HI:   kind_next = {frame_byte, 8'h00};
                    POS_KIND_LO:   kind_next = {kind_reg[15:8], frame_byte};
                    [6'd22:6'd29]: src_high_next = {src_high_reg[55:0], frame_byte};
                    [6'd30:6'd37]: src_low_next = {src_low_reg[55:0], frame_byte};
                    default:       kind_next = kind_reg;
                endcase
                if (pos_reg != MAX_POSITION)
                begin
                    pos_next = pos_reg + 6'd1;
                end
            end
        end
    end

    // The key bytes and the ethertype are all stored before the last byte of any
    // frame long enough to be counted, so the decision uses the registered state.
    always_comb
    begin
        if (kind_reg == KIND_IPV4 && pos_reg >= LAST_POS_IPV4)
        begin
            parse.counted = 1'b1;
            parse.key     = {64'd0, 16'd0, IPV4_MAPPED, src_high_reg[31:0]};
        end
        else if (kind_reg == KIND_IPV6 && pos_reg >= LAST_POS_IPV6)
        begin
            parse.counted = 1'b1;
            parse.key     = {src_high_reg, src_low_reg};
        end
        else
        begin
            parse.counted = 1'b0;
            parse.key     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            kind_reg     <= '0;
            src_high_reg <= '0;
            src_low_reg  <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            kind_reg     <= kind_next;
            src_high_reg <= src_high_next;
            src_low_reg  <= src_low_next;
        end
    end

endmodule

FILE: rtl/core/sibf_cell.sv
// One rule cell: holds a prefix rule and compares the key as the token passes.
module sibf_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  sibf_pkg::rule_t  rule,
    input  sibf_pkg::key_t   key,
    input  sibf_pkg::chain_t chain_in,
    output sibf_pkg::chain_t chain_out
);
    import sibf_pkg::*;

    logic       used_reg;
    logic [7:0] prefix_reg;
    key_t       address_reg;
    key_t       mask;
    logic       match;
    chain_t     chain_reg, chain_next;

    // A shift of 128 or more leaves nothing, so long prefixes compare every bit.
    assign mask  = ~({KEY_BITS{1'b1}} >> prefix_reg);
    assign match = used_reg && (((key ^ address_reg) & mask) == '0);

    always_comb
    begin
        chain_next.token = chain_in.token;
        chain_next.hit   = chain_in.hit || (chain_in.token && match);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            chain_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
            if (wr_en)
            begin
                used_reg <= rule.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && rule.valid)
        begin
            prefix_reg  <= rule.prefix_length;
            address_reg <= rule.address;
        end
    end

    assign chain_out = chain_reg;

endmodule

FILE: rtl/core/source_ip_blocklist_filter.sv
// Top level of the source address blocklist filter: parser, rule cell chain, counters.
//
// An item is taken at a clock edge where start is high and busy is low. An item is
// either one byte of an Ethernet frame or a write that stores or clears one rule.
// Rule writes and frame bytes that are not the last give no result.
// The last byte of a frame gives one result, shown on result for a single cycle
// with done high; the receiver cannot hold it off, so it must take it then.
// A frame that is not IPv4 or IPv6, or is too short, reports pass uncounted in the
// cycle after its last byte, and the next item may follow at once.
// A counted frame sends its key down a chain of RULE_ENTRIES cells, one cell per
// cycle, each comparing the key with its own rule; busy stays high meanwhile.
// Such a last byte holds busy until its token leaves the end of the chain, having passed
// go_reg and then each cell register in turn; its result is then registered with done.
// Frame bytes between last bytes run at one per cycle while busy is low.
// Reset clears the rule valid bits, the parser and both counters; the rule
// addresses and prefix lengths are undefined until written.
module source_ip_blocklist_filter #(
    parameter int RULE_ENTRIES = sibf_pkg::RULE_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sibf_pkg::in_item_t  item,
    output logic                done,
    output sibf_pkg::out_item_t result
);
    import sibf_pkg::*;

    logic      busy_reg, busy_next;
    logic      go_reg, go_next;
    logic      done_reg, done_next;
    key_t      key_reg;
    logic [63:0] passed_reg, passed_next;
    logic [63:0] dropped_reg, dropped_next;
    out_item_t result_reg, result_next;

    logic      accept;
    logic      frame_en;
    logic      last_en;
    logic      write_en;
    rule_t     rule;
    parse_t    parse;
    chain_t    chain [RULE_ENTRIES+1];

    assign accept   = start && !busy_reg;
    assign frame_en = accept && (item.operation == OP_FRAME_BYTE);
    assign last_en  = frame_en && item.frame_last;
    assign write_en = accept && (item.operation == OP_RULE_WRITE);

    assign rule.valid         = item.rule_valid;
    assign rule.prefix_length = item.rule_prefix_length;
    assign rule.address       = {item.rule_address_high, item.rule_address_low};

    sibf_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_en    (frame_en),
        .frame_byte (item.frame_byte),
        .frame_last (item.frame_last),
        .parse      (parse)
    );

    assign chain[0].token = go_reg;
    assign chain[0].hit   = 1'b0;

    for (genvar i = 0; i < RULE_ENTRIES; i++)
    begin : g_cell
        logic cell_wr;

        // Cells beyond the reach of the index field are never written.
        assign cell_wr = write_en && (32'(item.rule_index) == i);

        sibf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (cell_wr),
            .rule      (rule),
            .key       (key_reg),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    always_comb
    begin
        busy_next    = busy_reg;
        go_next      = last_en && parse.counted;
        done_next    = 1'b0;
        passed_next  = passed_reg;
        dropped_next = dropped_reg;
        result_next  = result_reg;
        if (last_en && parse.counted)
        begin
            busy_next = 1'b1;
        end
        else if (last_en)
        begin
            done_next                 = 1'b1;
            result_next.verdict       = 1'b0;
            result_next.was_counted   = 1'b0;
            result_next.passed_total  = passed_reg;
            result_next.dropped_total = dropped_reg;
        end
        if (chain[RULE_ENTRIES].token)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
            if (chain[RULE_ENTRIES].hit)
            begin
                dropped_next = dropped_reg + 64'd1;
            end
            else
            begin
                passed_next = passed_reg + 64'd1;
            end
            result_next.verdict       = chain[RULE_ENTRIES].hit;
            result_next.was_counted   = 1'b1;
            result_next.passed_total  = passed_next;
            result_next.dropped_total = dropped_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            go_reg      <= 1'b0;
            done_reg    <= 1'b0;
            passed_reg  <= '0;
            dropped_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            go_reg      <= go_next;
            done_reg    <= done_next;
            passed_reg  <= passed_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (last_en)
        begin
            key_reg <= parse.key;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // A result is only ever shown while no match is in flight.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while a match is still in flight");

    // The token leaving the chain always belongs to an item that holds busy.
    assert property (@(posedge clk) disable iff (!rst_n) chain[RULE_ENTRIES].token |-> busy_reg)
        else $error("token left the chain with no item in flight");

    // An uncounted frame is never dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.was_counted) |-> !result.verdict)
        else $error("uncounted frame reported as dropped");

    // Starting a match launches exactly one token into the chain.
    assert property (@(posedge clk) disable iff (!rst_n) go_reg |=> !go_reg)
        else $error("more than one token launched for a single frame");

endmodule
